// ===== sv/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== sv/cclm_pkg.sv =====
package cclm_pkg;

  localparam int CC_COUNT    = 128;
  localparam int PARAM_COUNT = 256;

  localparam int OP_W    = 2;
  localparam int PARAM_W = 8;
  localparam int CC_W    = 7;
  localparam int VAL_W   = 7;
  localparam int FRAC_W  = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_CC    = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // one result word
  typedef struct packed {
    logic               drive_valid;
    logic [PARAM_W-1:0] drive_param;
    logic [FRAC_W-1:0]  drive_fraction;
    logic               learned;
    logic [CC_W-1:0]    learned_cc;
    logic               query_found;
    logic [CC_W-1:0]    query_cc;
    logic               query_armed;
  } res_t;

  // table access from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [CC_W-1:0]    rd_addr;
    logic               wr_en;
    logic [CC_W-1:0]    wr_addr;
    logic [PARAM_W-1:0] wr_param;
    logic               clr_en;
    logic [CC_W-1:0]    clr_addr;
  } tbl_req_t;

  // registered read data of the table
  typedef struct packed {
    logic               valid;
    logic [PARAM_W-1:0] param;
  } tbl_rsp_t;

  // round(v * 65535 / 127): 65535 = 127 * 516 + 3, so the quotient is
  // 516 * v plus floor((3 * v + 63) / 127), which is at most 3
  function automatic logic [FRAC_W-1:0] scale_fraction(input logic [VAL_W-1:0] v);
    logic [FRAC_W-1:0] base;
    logic [8:0]        rem;
    logic [1:0]        q;
    base = FRAC_W'(v) * 16'd516;
    rem  = 9'(v) * 9'd3 + 9'd63;
    if (rem >= 9'd381) begin
      q = 2'd3;
    end else if (rem >= 9'd254) begin
      q = 2'd2;
    end else if (rem >= 9'd127) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return base + FRAC_W'(q);
  endfunction

endpackage

// ===== sv/cclm_in_if.sv =====
interface cclm_in_if;
  logic                        valid;
  logic                        ready;
  logic [cclm_pkg::OP_W-1:0]    op;
  logic [cclm_pkg::PARAM_W-1:0] param_index;
  logic [cclm_pkg::CC_W-1:0]    cc_number;
  logic [cclm_pkg::VAL_W-1:0]   cc_value;

  modport source (output valid, output op, output param_index, output cc_number,
                  output cc_value, input ready);
  modport sink (input valid, input op, input param_index, input cc_number,
                input cc_value, output ready);
endinterface

// ===== sv/cclm_out_if.sv =====
interface cclm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        drive_valid;
  logic [cclm_pkg::PARAM_W-1:0] drive_param;
  logic [cclm_pkg::FRAC_W-1:0]  drive_fraction;
  logic                        learned;
  logic [cclm_pkg::CC_W-1:0]    learned_cc;
  logic                        query_found;
  logic [cclm_pkg::CC_W-1:0]    query_cc;
  logic                        query_armed;

  modport source (output valid, output drive_valid, output drive_param,
                  output drive_fraction, output learned, output learned_cc,
                  output query_found, output query_cc, output query_armed,
                  input ready);
  modport sink (input valid, input drive_valid, input drive_param,
                input drive_fraction, input learned, input learned_cc,
                input query_found, input query_cc, input query_armed,
                output ready);
endinterface

// ===== sv/cclm_table.sv =====
`include "assert_macros.svh"

module cclm_table #(
  parameter int CC_COUNT = cclm_pkg::CC_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  cclm_pkg::tbl_req_t req,
  output cclm_pkg::tbl_rsp_t rsp
);

  localparam int IDX_W = $clog2(CC_COUNT);

  logic [cclm_pkg::PARAM_W-1:0] mem [CC_COUNT];
  logic [CC_COUNT-1:0]          valid;
  logic [cclm_pkg::PARAM_W-1:0] rd_param;
  logic                         rd_valid;

  // parameter store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IDX_W-1:0]] <= req.wr_param;
    end
    if (req.rd_en) begin
      rd_param <= mem[req.rd_addr[IDX_W-1:0]];
    end
  end

  // bound flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.clr_en) begin
        valid[req.clr_addr[IDX_W-1:0]] <= 1'b0;
      end
      if (req.wr_en) begin
        valid[req.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr[IDX_W-1:0]];
      end
    end
  end

  assign rsp.valid = rd_valid;
  assign rsp.param = rd_param;

  `ASSERT_CLK(a_wr_binds, clk, rst, req.wr_en |=> valid[$past(req.wr_addr[IDX_W-1:0])], "written entry not bound")
  `ASSERT_NEVER(a_clr_wr_overlap, clk, rst, req.wr_en && req.clr_en, "clear and bind in one cycle")

endmodule

// ===== sv/cclm_ctrl.sv =====
`include "assert_macros.svh"

module cclm_ctrl #(
  parameter int CC_COUNT = cclm_pkg::CC_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  cclm_in_if.sink            in_ch,
  output cclm_pkg::tbl_req_t req,
  input  cclm_pkg::tbl_rsp_t rsp,
  output cclm_pkg::res_t     res,
  output logic               res_valid,
  input  logic               res_ready
);

  localparam int IDX_W = $clog2(CC_COUNT);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0]                   state;
  logic [cclm_pkg::OP_W-1:0]    op_q;
  logic [cclm_pkg::PARAM_W-1:0] key;
  logic [cclm_pkg::CC_W-1:0]    cc_q;
  logic [cclm_pkg::VAL_W-1:0]   val_q;
  logic                         armed_v;
  logic [cclm_pkg::PARAM_W-1:0] armed_p;
  logic [IDX_W-1:0]             cnt;
  logic                         issue_done;
  logic                         cmp_act;
  logic [IDX_W-1:0]             cmp_idx;
  logic                         accept;
  logic                         in_range;
  logic                         hit;
  cclm_pkg::res_t               res_init;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.cc_number) < CC_COUNT;
  assign res_valid   = (state == ST_PUT);

  // entry read in the previous cycle matches the key
  assign hit = cmp_act && rsp.valid && (rsp.param == key);

  // result word at acceptance, a query reports whether its parameter is armed
  always_comb begin
    res_init             = '0;
    res_init.query_armed = (in_ch.op == cclm_pkg::OP_QUERY) && armed_v &&
                           (armed_p == in_ch.param_index);
  end

  // table requests
  always_comb begin
    req.rd_en    = (accept && (in_ch.op == cclm_pkg::OP_CC) && in_range && !armed_v) ||
                   ((state == ST_WALK) && !issue_done);
    req.rd_addr  = (state == ST_WALK) ? cclm_pkg::CC_W'(cnt) : in_ch.cc_number;
    req.clr_en   = (state == ST_WALK) && hit && (op_q != cclm_pkg::OP_QUERY);
    req.clr_addr = cclm_pkg::CC_W'(cmp_idx);
    req.wr_en    = (state == ST_FIN);
    req.wr_addr  = cc_q;
    req.wr_param = key;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      armed_v    <= 1'b0;
      cmp_act    <= 1'b0;
      issue_done <= 1'b0;
      cnt        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt        <= '0;
            issue_done <= 1'b0;
            cmp_act    <= 1'b0;
            unique case (in_ch.op) inside
              cclm_pkg::OP_CC: begin
                if (!in_range) begin
                  state <= ST_PUT;
                end else if (armed_v) begin
                  state <= ST_WALK;
                end else begin
                  state <= ST_READ;
                end
              end
              cclm_pkg::OP_ARM: begin
                armed_v <= 32'(in_ch.param_index) < cclm_pkg::PARAM_COUNT;
                state   <= ST_PUT;
              end
              cclm_pkg::OP_CLEAR, cclm_pkg::OP_QUERY: begin
                state <= ST_WALK;
              end
              default: begin
                state <= ST_PUT;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_PUT;
        end
        ST_WALK: begin
          // the compare follows the address issue in the next cycle
          if (!issue_done) begin
            cnt <= cnt + IDX_W'(1);
            if (cnt == IDX_W'(CC_COUNT - 1)) begin
              issue_done <= 1'b1;
            end
          end
          cmp_act <= !issue_done;
          if (issue_done && !cmp_act) begin
            state <= (op_q == cclm_pkg::OP_CC) ? ST_FIN : ST_PUT;
          end
        end
        ST_FIN: begin
          armed_v <= 1'b0;
          state   <= ST_PUT;
        end
        ST_PUT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // operands and result word
  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    if (accept) begin
      op_q  <= in_ch.op;
      cc_q  <= in_ch.cc_number;
      val_q <= in_ch.cc_value;
      key   <= (in_ch.op == cclm_pkg::OP_CC) ? armed_p : in_ch.param_index;
      res   <= res_init;
      if (in_ch.op == cclm_pkg::OP_ARM) begin
        armed_p <= in_ch.param_index;
      end
    end
    if (state == ST_READ) begin
      res.drive_valid <= rsp.valid;
      if (rsp.valid) begin
        res.drive_param    <= rsp.param;
        res.drive_fraction <= cclm_pkg::scale_fraction(val_q);
      end
    end
    // lowest matching number wins
    if ((state == ST_WALK) && hit && (op_q == cclm_pkg::OP_QUERY) && !res.query_found) begin
      res.query_found <= 1'b1;
      res.query_cc    <= cclm_pkg::CC_W'(cmp_idx);
    end
    if (state == ST_FIN) begin
      res.learned        <= 1'b1;
      res.learned_cc     <= cc_q;
      res.drive_valid    <= 1'b1;
      res.drive_param    <= key;
      res.drive_fraction <= cclm_pkg::scale_fraction(val_q);
    end
  end

  `ASSERT_CLK(a_learn_disarms, clk, rst, state == ST_FIN |=> !armed_v, "learning still armed")
  `ASSERT_CLK(a_learn_drives, clk, rst, res_valid && res.learned |-> res.drive_valid && res.drive_param == key, "learned binding not driven")
  `ASSERT_CLK(a_query_cc_zero, clk, rst, res_valid && !res.query_found |-> res.query_cc == '0, "query number without match")

endmodule

// ===== sv/midi_cc_learn_map_top.sv =====
// controller learn and mapping table
// in_ch carries one request word: op selects controller message, arm learn,
// clear binding or query parameter; out_ch returns exactly one result word
// for each request, in request order.
// a controller message without armed learning reads its table entry;
// its result passes through the READ and PUT states into the output register.
// arm learn goes straight to the PUT state and on into the output register.
// a controller message with learning armed, clear and query scan every
// table entry, one per cycle through the single memory read port; learning
// then writes the new binding in the FIN state.
// one request is in flight at a time; in_ch.ready rises again once the
// result has moved into the output register, so the next request can be
// accepted while out_ch still waits for its receiver.
// when out_ch stalls the result word is held and the sequencer waits with
// its next result.
// reset (rst, synchronous) unbinds every entry and disarms learning at once;
// no clearing pass is needed.
module midi_cc_learn_map_top #(
  parameter int CC_COUNT = cclm_pkg::CC_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  cclm_in_if.sink    in_ch,
  cclm_out_if.source out_ch
);

  cclm_pkg::tbl_req_t req;
  cclm_pkg::tbl_rsp_t rsp;
  cclm_pkg::res_t     res;
  cclm_pkg::res_t     out_q;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid;

  cclm_ctrl #(
    .CC_COUNT(CC_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .req       (req),
    .rsp       (rsp),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  cclm_table #(
    .CC_COUNT(CC_COUNT)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // output register
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.drive_valid    = out_q.drive_valid;
  assign out_ch.drive_param    = out_q.drive_param;
  assign out_ch.drive_fraction = out_q.drive_fraction;
  assign out_ch.learned        = out_q.learned;
  assign out_ch.learned_cc     = out_q.learned_cc;
  assign out_ch.query_found    = out_q.query_found;
  assign out_ch.query_cc       = out_q.query_cc;
  assign out_ch.query_armed    = out_q.query_armed;

endmodule
